>>> sv/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> sv/ewrt_pkg.sv
// ----------------------------------------------------------------------------
// ewrt_pkg
// Constants, types and helper functions of the EWMA event rate estimator.
// ----------------------------------------------------------------------------
package ewrt_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int TIME_W      = 64;
    localparam int RATE_W      = 46;
    localparam int CFG_ALPHA_W = 17;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int ALPHA_W     = FRAC_BITS + 1;

    localparam logic [63:0] NS_PER_S = 64'd1000000000;

    // Dividend of the instantaneous rate: one second in ns, scaled to fixed point.
    localparam int DVD_W = $clog2(NS_PER_S) + FRAC_BITS;
    localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(NS_PER_S << FRAC_BITS);

    localparam int MAX_IN_W = (DVD_W > RATE_W) ? DVD_W : RATE_W;
    localparam int SUM_W    = FRAC_BITS + MAX_IN_W + 1;

    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int MUL_CNT_W = $clog2(ALPHA_W);

    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    // Largest rate the block can ever report.
    localparam logic [RATE_W-1:0] RATE_CAP =
        (DVD_W > RATE_W) ? RATE_MAX : RATE_W'(DIVIDEND);

    localparam logic [ALPHA_W-1:0] ONE = ALPHA_W'(32'd1 << FRAC_BITS);

    localparam logic [CFG_ALPHA_W-1:0] DEFAULT_ALPHA = 17'd8192;
    localparam logic [CFG_ALPHA_W-1:0] ALPHA_RST     = 17'd8192;
    localparam logic [TIME_W-1:0]      STALE_RST     = 64'd1000000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA = 1'b0,
        CFG_STALE = 1'b1
    } t_cfg_idx;

    localparam logic KIND_EVENT = 1'b0;

    // Zero selects the default weight; anything above one is clamped.
    function automatic logic [ALPHA_W-1:0] eff_alpha(input logic [CFG_ALPHA_W-1:0] a);
        logic [31:0] v;
        v = (a == '0) ? 32'(DEFAULT_ALPHA) : 32'(a);
        if (v > 32'(ONE)) begin
            v = 32'(ONE);
        end
        return ALPHA_W'(v);
    endfunction

endpackage

>>> sv/ewrt_in_if.sv
// ----------------------------------------------------------------------------
// ewrt_in_if
// Input channel: event or query with its timestamp.
// ----------------------------------------------------------------------------
interface ewrt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [ewrt_pkg::TIME_W-1:0] time_ns;

    modport source (output valid, output kind, output time_ns, input ready);
    modport sink   (input valid, input kind, input time_ns, output ready);
endinterface

>>> sv/ewrt_out_if.sv
// ----------------------------------------------------------------------------
// ewrt_out_if
// Output channel: reported rate in fixed point.
// ----------------------------------------------------------------------------
interface ewrt_out_if;
    logic                        valid;
    logic                        ready;
    logic [ewrt_pkg::RATE_W-1:0] rate_q16;

    modport source (output valid, output rate_q16, input ready);
    modport sink   (input valid, input rate_q16, output ready);
endinterface

>>> sv/ewma_event_rate_estimator_top.sv
// A query passes through the gap, age and check states before its result is registered.
// An event after the first also passes through the 46-step bit-serial divider and the
// 17-step bit-serial blend; the next item is taken only once the event is through.
// The result register lets a new item in while an earlier result is not yet taken.
// Synchronous reset clears the state, restores both registers and forgets all events.
// ----------------------------------------------------------------------------
// ewma_event_rate_estimator_top
// Smoothed event rate in fixed point from timestamped events and queries.
// ----------------------------------------------------------------------------
module ewma_event_rate_estimator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ewrt_in_if.sink                           i_in,
    ewrt_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [ewrt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ewrt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GAP  = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_AGE  = 6'b010000,
        S_CHK  = 6'b100000
    } t_state;

    t_state                                r_state, n_state;
    logic [ewrt_pkg::CFG_ALPHA_W-1:0]      r_alpha;
    logic [ewrt_pkg::TIME_W-1:0]           r_stale;
    logic [ewrt_pkg::TIME_W-1:0]           r_last, n_last;
    logic [ewrt_pkg::RATE_W-1:0]           r_rate, n_rate;
    logic [ewrt_pkg::TIME_W-1:0]           r_now;
    logic                                  r_kind;
    logic [ewrt_pkg::TIME_W-1:0]           r_age, n_age;
    logic                                  r_out_valid, n_out_valid;
    logic [ewrt_pkg::RATE_W-1:0]           r_out_rate, n_out_rate;

    logic                                  accept;
    logic                                  later;
    logic [ewrt_pkg::TIME_W-1:0]           diff;
    logic                                  div_start, div_done;
    logic [ewrt_pkg::TIME_W-1:0]           div_gap;
    logic [ewrt_pkg::DVD_W-1:0]            div_quot;
    logic                                  mul_start, mul_done;
    logic [ewrt_pkg::RATE_W-1:0]           mul_rate;
    logic                                  out_free;

    assign accept   = i_in.valid && i_in.ready;
    assign later    = r_now > r_last;
    assign diff     = r_now - r_last;
    assign div_gap  = later ? diff : ewrt_pkg::TIME_W'(1);
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.rate_q16 = r_out_rate;

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_rate      = r_rate;
        n_age       = r_age;
        n_out_valid = r_out_valid;
        n_out_rate  = r_out_rate;
        div_start   = 1'b0;
        mul_start   = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                if (r_kind == ewrt_pkg::KIND_EVENT) begin
                    n_last = r_now;
                    // The first event only records its time.
                    if (r_last != '0) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_AGE;
                    end
                end else begin
                    n_state = S_AGE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_rate  = mul_rate;
                    n_state = S_AGE;
                end
            end
            S_AGE: begin
                n_age   = later ? diff : '0;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rate  = ((r_last != '0) && (r_age < r_stale)) ? r_rate : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
            r_alpha     <= ewrt_pkg::ALPHA_RST;
            r_stale     <= ewrt_pkg::STALE_RST;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_rate      <= n_rate;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (ewrt_pkg::t_cfg_idx'(i_cfg_idx))
                    ewrt_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[ewrt_pkg::CFG_ALPHA_W-1:0];
                    ewrt_pkg::CFG_STALE: r_stale <= i_cfg_data[ewrt_pkg::TIME_W-1:0];
                    default:             r_stale <= r_stale;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now  <= i_in.time_ns;
            r_kind <= i_in.kind;
        end
        r_age      <= n_age;
        r_out_rate <= n_out_rate;
    end

    ewrt_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (div_gap),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    ewrt_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_alpha (ewrt_pkg::eff_alpha(r_alpha)),
        .i_inst  (div_quot),
        .i_rate  (r_rate),
        .o_done  (mul_done),
        .o_rate  (mul_rate)
    );

endmodule

>>> sv/ewrt_div.sv
// ----------------------------------------------------------------------------
// ewrt_div
// Bit-serial restoring divider: constant dividend over a 64-bit gap,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ewrt_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ewrt_pkg::TIME_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [ewrt_pkg::DVD_W-1:0]   o_quot
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [ewrt_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [ewrt_pkg::TIME_W-1:0]       r_rem, n_rem;
    logic [ewrt_pkg::TIME_W-1:0]       r_dvs, n_dvs;
    // Holds the remaining dividend bits at the top and the quotient bits below.
    logic [ewrt_pkg::DVD_W-1:0]        r_q, n_q;
    logic [ewrt_pkg::TIME_W:0]         trial;
    logic                              fits;

    assign trial = {r_rem, r_q[ewrt_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = ewrt_pkg::DIV_CNT_W'(ewrt_pkg::DVD_W - 1);
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_q    = ewrt_pkg::DIVIDEND;
        end else if (r_busy) begin
            n_rem = fits ? ewrt_pkg::TIME_W'(trial - {1'b0, r_dvs})
                         : trial[ewrt_pkg::TIME_W-1:0];
            n_q   = {r_q[ewrt_pkg::DVD_W-2:0], fits};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> sv/ewrt_blend.sv
// ----------------------------------------------------------------------------
// ewrt_blend
// Bit-serial weighted blend of the new sample and the kept rate, one bit
// of the weight per cycle, with saturation of the result.
// ----------------------------------------------------------------------------
module ewrt_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ewrt_pkg::ALPHA_W-1:0]  i_alpha,
    input  logic [ewrt_pkg::DVD_W-1:0]    i_inst,
    input  logic [ewrt_pkg::RATE_W-1:0]   i_rate,
    output logic                          o_done,
    output logic [ewrt_pkg::RATE_W-1:0]   o_rate
);

    localparam int HI_W = ewrt_pkg::SUM_W - ewrt_pkg::FRAC_BITS;

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [ewrt_pkg::MUL_CNT_W-1:0]    r_cnt, n_cnt;
    logic [ewrt_pkg::ALPHA_W-1:0]      r_a, n_a;
    logic [ewrt_pkg::ALPHA_W-1:0]      r_b, n_b;
    logic [ewrt_pkg::DVD_W-1:0]        r_inst, n_inst;
    logic [ewrt_pkg::RATE_W-1:0]       r_rate, n_rate;
    logic [ewrt_pkg::SUM_W-1:0]        r_acc, n_acc;
    logic [ewrt_pkg::SUM_W-1:0]        add_i, add_r;
    logic [HI_W-1:0]                   sum_hi;

    assign add_i = r_a[ewrt_pkg::ALPHA_W-1] ? ewrt_pkg::SUM_W'(r_inst) : '0;
    assign add_r = r_b[ewrt_pkg::ALPHA_W-1] ? ewrt_pkg::SUM_W'(r_rate) : '0;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_inst = r_inst;
        n_rate = r_rate;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = ewrt_pkg::MUL_CNT_W'(ewrt_pkg::ALPHA_W - 1);
            n_a    = i_alpha;
            n_b    = ewrt_pkg::ONE - i_alpha;
            n_inst = i_inst;
            n_rate = i_rate;
            n_acc  = '0;
        end else if (r_busy) begin
            // Weight bits are taken from the top, so the sum is doubled each step.
            n_acc = (r_acc << 1) + add_i + add_r;
            n_a   = r_a << 1;
            n_b   = r_b << 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_inst <= n_inst;
        r_rate <= n_rate;
        r_acc  <= n_acc;
    end

    assign sum_hi = r_acc[ewrt_pkg::SUM_W-1:ewrt_pkg::FRAC_BITS];
    assign o_done = r_done;
    assign o_rate = (|(sum_hi >> ewrt_pkg::RATE_W)) ? ewrt_pkg::RATE_MAX
                                                    : sum_hi[ewrt_pkg::RATE_W-1:0];

endmodule

>>> sv/ewrt_chk.sv
// ----------------------------------------------------------------------------
// ewrt_chk
// Port-level checks of the rate estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ewrt_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [ewrt_pkg::RATE_W-1:0]   i_out_rate
);

    // Only one item is worked on at a time.
    `ASSERT_CLK(a_one_item, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready)

    // A stalled result stays in place.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_rate)))

    // A blend of sample rates never exceeds the largest possible sample rate.
    `ASSERT_CLK(a_rate_cap, i_clk, i_rst_n, i_out_valid |-> (i_out_rate <= ewrt_pkg::RATE_CAP))

    // Reset leaves no result pending.
    `ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind ewma_event_rate_estimator_top ewrt_chk u_ewrt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_rate  (o_out.rate_q16)
);
